[src/fifo_queue_with_sorted_insert_defines.svh]
// Assertion macros shared by the queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FIFO_QUEUE_WITH_SORTED_INSERT_DEFINES_SVH
`define FIFO_QUEUE_WITH_SORTED_INSERT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FQSI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FQSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/fqsi_pkg.sv]
// Shared types, constants and helpers for the sorted-insert queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fqsi_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int CNT_FIELD_W = 5;

    typedef enum logic [1:0] {
        ACT_ENQ = 2'd0,
        ACT_DEQ = 2'd1,
        ACT_CLR = 2'd2,
        ACT_INS = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_HOLD = 1'b1
    } ctrl_state_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } dp_cmd_t;

    // Reported count is the fill level modulo 32.
    function automatic logic [CNT_FIELD_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+CNT_FIELD_W-1:0] wide;
        wide = {{CNT_FIELD_W{1'b0}}, c};
        return wide[CNT_FIELD_W-1:0];
    endfunction

endpackage

[src/fqsi_ctrl.sv]
// Handshake controller: tracks whether the result register holds a word.
// Depends on fqsi_pkg.
`timescale 1ns / 1ps

module fqsi_ctrl import fqsi_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd.exec   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                cmd.exec = s_tvalid;
                if (s_tvalid) begin
                    state_next = CS_HOLD;
                end
            end
            CS_HOLD: begin
                // A new word may replace the result in the cycle it is taken.
                m_tvalid = 1'b1;
                s_tready = m_tready;
                cmd.exec = s_tvalid && m_tready;
                if (m_tready && !s_tvalid) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

[src/fqsi_datapath.sv]
// Queue datapath: a chain of entry cells, the fill count and the result register.
// Depends on fqsi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fifo_queue_with_sorted_insert_defines.svh"

module fqsi_datapath import fqsi_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    input  action_t                action,
    input  logic signed [VAL_W-1:0] value,
    output logic signed [VAL_W-1:0] popped_value,
    output logic                   popped_valid,
    output status_t                status,
    output logic [CNT_FIELD_W-1:0] count
);

    logic signed [VAL_W-1:0] cells_reg [DEPTH];
    logic signed [VAL_W-1:0] cells_next [DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [VAL_W-1:0] pop_value_reg;
    logic signed [VAL_W-1:0] pop_value_next;
    logic                    pop_valid_reg;
    logic                    pop_valid_next;
    status_t                 status_reg;
    status_t                 status_next;

    logic             full;
    logic             empty;
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] at_or_after;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // A cell past the fill level counts as "not less", so an insert with no
    // entry greater than or equal to it lands at the tail.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = (CNT_W'(i) >= count_reg) || (cells_reg[i] >= value);
        end
        for (int i = 0; i < DEPTH; i++) begin
            at_or_after[i] = 1'b0;
            for (int j = 0; j <= i; j++) begin
                at_or_after[i] = at_or_after[i] | ge[j];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cells_next[i] = cells_reg[i];
        end
        count_next     = count_reg;
        pop_value_next = pop_value_reg;
        pop_valid_next = pop_valid_reg;
        status_next    = status_reg;
        if (cmd.exec) begin
            pop_value_next = '0;
            pop_valid_next = 1'b0;
            status_next    = STAT_OK;
            case (action)
                ACT_ENQ: begin
                    if (full) begin
                        status_next = STAT_FULL;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (CNT_W'(i) == count_reg) begin
                                cells_next[i] = value;
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_DEQ: begin
                    if (empty) begin
                        status_next = STAT_EMPTY;
                    end else begin
                        pop_value_next = cells_reg[0];
                        pop_valid_next = 1'b1;
                        for (int i = 0; i < DEPTH - 1; i++) begin
                            cells_next[i] = cells_reg[i+1];
                        end
                        count_next = count_reg - 1'b1;
                    end
                end
                ACT_CLR: begin
                    count_next = '0;
                end
                ACT_INS: begin
                    if (full) begin
                        status_next = STAT_FULL;
                    end else begin
                        if (at_or_after[0]) begin
                            cells_next[0] = value;
                        end
                        for (int i = 1; i < DEPTH; i++) begin
                            if (at_or_after[i] && !at_or_after[i-1]) begin
                                cells_next[i] = value;
                            end else if (at_or_after[i]) begin
                                cells_next[i] = cells_reg[i-1];
                            end
                        end
                        count_next = count_reg + 1'b1;
                    end
                end
                default: begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            cells_reg[i] <= cells_next[i];
        end
        pop_value_reg <= pop_value_next;
        pop_valid_reg <= pop_valid_next;
        status_reg    <= status_next;
    end

    assign popped_value = pop_value_reg;
    assign popped_valid = pop_valid_reg;
    assign status       = status_reg;
    assign count        = count_field(count_reg);

    `FQSI_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH),
        "fill count exceeds depth")
    `FQSI_ASSERT_NEXT(a_clear_empties, aclk, aresetn, cmd.exec && action == ACT_CLR,
        count_reg == '0 && status_reg == STAT_OK, "clear did not empty the queue")
    `FQSI_ASSERT_NEXT(a_full_drop, aclk, aresetn,
        cmd.exec && full && (action == ACT_ENQ || action == ACT_INS),
        status_reg == STAT_FULL && $stable(count_reg), "write into full queue changed it")
    `FQSI_ASSERT_NEXT(a_pop_count, aclk, aresetn, cmd.exec && action == ACT_DEQ && !empty,
        pop_valid_reg && count_reg == $past(count_reg) - 1'b1, "dequeue count mismatch")

endmodule

[src/fifo_queue_with_sorted_insert.sv]
// Top level of the sorted-insert queue: controller plus datapath.
// Depends on fqsi_pkg, fqsi_ctrl and fqsi_datapath.
//
// Usage:
//   Input channel (s_): one word per action. s_tuser carries the action
//   (enqueue, dequeue, clear, sorted insert), s_tdata the signed value.
//   Result channel (m_): exactly one word per accepted action, in order,
//   with the dequeued value, a valid flag, a status code and the count.
//   Latency: the result is valid the cycle after the action is accepted.
//   Throughput: one action per cycle while no result is stalled; each action,
//   including a sorted insert, compares and shifts every entry cell combinationally.
//   The result register frees itself in the cycle its word is taken, so
//   s_tready follows m_tready while a result is pending.
//   Reset (aresetn low, synchronous) empties the queue and drops any
//   pending result; entry contents are not cleared.
//   If the receiver stalls, the result word holds and no new action is
//   accepted until it is taken.
`timescale 1ns / 1ps

module fifo_queue_with_sorted_insert import fqsi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] value
    input  logic [1:0]  s_tuser,  // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [31:0] popped_value, [36:32] count, [39:37] zero
    output logic [2:0]  m_tuser   // [0] popped_valid, [2:1] status
);

    dp_cmd_t                  cmd;
    logic signed [VAL_W-1:0]  popped_value;
    logic                     popped_valid;
    status_t                  status;
    logic [CNT_FIELD_W-1:0]   count;

    fqsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fqsi_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .action       (action_t'(s_tuser)),
        .value        ($signed(s_tdata)),
        .popped_value (popped_value),
        .popped_valid (popped_valid),
        .status       (status),
        .count        (count)
    );

    assign m_tdata = {3'b000, count, popped_value};
    assign m_tuser = {status, popped_valid};

endmodule
